// ===== sv/ctc_pkg.sv =====
// shared types and constants for the command line token checker
package ctc_pkg;

  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned NUM_ARGS   = 4;
  localparam int unsigned MAX_TOKENS = 5;
  localparam int unsigned VALUE_W    = 34;
  localparam int unsigned ARG_LEN_W  = 4;

  localparam logic [7:0] BYTE_HASH  = 8'h23;
  localparam logic [7:0] BYTE_NL    = 8'h0A;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] CTRL_LIMIT = 8'd33;

  typedef enum logic [1:0] {
    VERDICT_IGNORE    = 2'd0,
    VERDICT_MALFORMED = 2'd1,
    VERDICT_COMMAND   = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } in_req_t;

  typedef struct packed {
    verdict_e               verdict;
    logic [7:0]             command_char;
    logic [7:0]             command_length;
    logic [2:0]             arg_count;
    logic [VALUE_W-1:0]     first_value;
    logic [VALUE_W-1:0]     second_value;
    logic [VALUE_W-1:0]     third_value;
    logic [VALUE_W-1:0]     fourth_value;
    logic [ARG_LEN_W-1:0]   first_length;
    logic [ARG_LEN_W-1:0]   second_length;
    logic [ARG_LEN_W-1:0]   third_length;
    logic [ARG_LEN_W-1:0]   fourth_length;
  } out_rsp_t;

endpackage

// ===== sv/command_line_token_checker.sv =====
// command line token checker: per-byte line scan with one verdict per line
// order: a byte is registered in the input register at accept and scanned when it
// may proceed; the verdict of a line is registered in the result register by that scan
// throughput: one byte per cycle, set by the single per-byte scan step; stalls
// only while a verdict waits on out_ready_i and the next last byte needs the slot
// reset: rst_ni clears both handshakes and puts the scanner at a line start
module command_line_token_checker #(
  parameter int unsigned MaxDigits = ctc_pkg::MAX_DIGITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ctc_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ctc_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned NumArgs = ctc_pkg::NUM_ARGS;
  localparam int unsigned ValW    = ctc_pkg::VALUE_W;
  localparam int unsigned LenW    = $clog2(MaxDigits + 2);
  localparam int unsigned LenSat  = MaxDigits + 1;
  localparam int unsigned LenCap  = (MaxDigits + 1 > 15) ? 15 : MaxDigits + 1;

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // line scan state
  logic            at_start_q, at_start_d;
  logic            comment_q, comment_d;
  logic            err_q, err_d;
  logic [2:0]      tok_idx_q, tok_idx_d;
  logic            in_tok_q, in_tok_d;
  logic            lead_zero_q, lead_zero_d;
  logic [7:0]      cmd_byte_q, cmd_byte_d;
  logic [1:0]      cmd_len_q, cmd_len_d;
  logic [ValW-1:0] arg_val_q [NumArgs];
  logic [ValW-1:0] arg_val_d [NumArgs];
  logic [LenW-1:0] arg_len_q [NumArgs];
  logic [LenW-1:0] arg_len_d [NumArgs];

  // result register
  logic              out_vld_q, out_vld_d;
  ctc_pkg::out_rsp_t out_rsp_q, out_rsp_d;

  logic step;
  logic proceed;

  assign proceed    = !in_last_q || !out_vld_q || out_ready_i;
  assign step       = in_vld_q && proceed;
  assign in_ready_o = !in_vld_q || proceed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_req_i.text_byte;
      in_last_q <= in_req_i.line_end;
    end
  end

  // per-byte scan
  logic            sp, is_digit, first;
  logic [2:0]      tok_new;
  logic [1:0]      slot;
  logic [LenW-1:0] pos, len_new;
  logic [ValW-1:0] val_sel, val_new;
  logic [3:0]      digit;
  ctc_pkg::verdict_e verdict;

  always_comb begin
    at_start_d  = at_start_q;
    comment_d   = comment_q;
    err_d       = err_q;
    tok_idx_d   = tok_idx_q;
    in_tok_d    = in_tok_q;
    lead_zero_d = lead_zero_q;
    cmd_byte_d  = cmd_byte_q;
    cmd_len_d   = cmd_len_q;
    for (int i = 0; i < NumArgs; i++) begin
      arg_val_d[i] = arg_val_q[i];
      arg_len_d[i] = arg_len_q[i];
    end
    out_vld_d = out_vld_q && !out_ready_i;
    out_rsp_d = out_rsp_q;

    first    = at_start_q;
    sp       = (in_byte_q == ctc_pkg::BYTE_SPACE) ||
               ((in_byte_q >= ctc_pkg::BYTE_TAB) && (in_byte_q <= ctc_pkg::BYTE_CR));
    is_digit = (in_byte_q >= ctc_pkg::BYTE_ZERO) &&
               (in_byte_q <= ctc_pkg::BYTE_ZERO + 8'd9);
    digit    = 4'(in_byte_q - ctc_pkg::BYTE_ZERO);
    tok_new  = tok_idx_q;
    slot     = 2'(tok_idx_q - 3'd2);
    pos      = arg_len_q[slot];
    val_sel  = arg_val_q[slot];
    val_new  = val_sel;
    len_new  = pos;
    verdict  = ctc_pkg::VERDICT_IGNORE;

    if (step) begin
      at_start_d = 1'b0;
      if (first && ((in_byte_q == ctc_pkg::BYTE_HASH) ||
                    ((in_byte_q == ctc_pkg::BYTE_NL) && in_last_q))) begin
        comment_d = 1'b1;
      end

      if (!comment_d) begin
        if ((in_byte_q < ctc_pkg::CTRL_LIMIT) && !sp) begin
          err_d = 1'b1;
        end
        if (sp) begin
          if (first) begin
            err_d = 1'b1;
          end
          in_tok_d = 1'b0;
        end else begin
          if (!in_tok_q) begin
            in_tok_d    = 1'b1;
            lead_zero_d = 1'b0;
            if (tok_idx_q <= 3'(ctc_pkg::MAX_TOKENS)) begin
              tok_new = tok_idx_q + 3'd1;
            end
            if (tok_new > 3'(ctc_pkg::MAX_TOKENS)) begin
              err_d = 1'b1;
            end
          end
          tok_idx_d = tok_new;
          slot      = 2'(tok_new - 3'd2);
          pos       = arg_len_q[slot];
          val_sel   = arg_val_q[slot];

          if (tok_new == 3'd1) begin
            // command token
            if (cmd_len_q == 2'd0) begin
              cmd_byte_d = in_byte_q;
            end
            if (cmd_len_q != 2'd2) begin
              cmd_len_d = cmd_len_q + 2'd1;
            end
          end else if ((tok_new >= 3'd2) && (tok_new <= 3'(ctc_pkg::MAX_TOKENS))) begin
            // argument token
            if ((pos != '0) && lead_zero_d) begin
              err_d = 1'b1;
            end
            val_new = val_sel;
            if (!is_digit) begin
              err_d = 1'b1;
            end else if (pos < LenW'(MaxDigits)) begin
              val_new = (val_sel << 3) + (val_sel << 1) + ValW'(digit);
            end
            if ((pos == '0) && (in_byte_q == ctc_pkg::BYTE_ZERO)) begin
              lead_zero_d = 1'b1;
            end
            len_new = (pos < LenW'(LenSat)) ? pos + LenW'(1) : pos;
            if (len_new > LenW'(MaxDigits)) begin
              err_d = 1'b1;
            end
            arg_val_d[slot] = val_new;
            arg_len_d[slot] = len_new;
          end
        end
        if (in_last_q && (in_byte_q != ctc_pkg::BYTE_NL)) begin
          err_d = 1'b1;
        end
      end

      if (in_last_q) begin
        priority if (comment_d) begin
          verdict = ctc_pkg::VERDICT_IGNORE;
        end else if (err_d || (cmd_len_d != 2'd1)) begin
          verdict = ctc_pkg::VERDICT_MALFORMED;
        end else begin
          verdict = ctc_pkg::VERDICT_COMMAND;
        end

        out_vld_d = 1'b1;
        out_rsp_d = '0;
        out_rsp_d.verdict = verdict;
        if (verdict == ctc_pkg::VERDICT_COMMAND) begin
          out_rsp_d.command_char   = cmd_byte_d;
          out_rsp_d.command_length = 8'(cmd_len_d);
          out_rsp_d.arg_count      = tok_idx_d - 3'd1;
          out_rsp_d.first_value    = arg_val_d[0];
          out_rsp_d.second_value   = arg_val_d[1];
          out_rsp_d.third_value    = arg_val_d[2];
          out_rsp_d.fourth_value   = arg_val_d[3];
          out_rsp_d.first_length   = 4'((arg_len_d[0] > LenW'(LenCap)) ?
                                        LenW'(LenCap) : arg_len_d[0]);
          out_rsp_d.second_length  = 4'((arg_len_d[1] > LenW'(LenCap)) ?
                                        LenW'(LenCap) : arg_len_d[1]);
          out_rsp_d.third_length   = 4'((arg_len_d[2] > LenW'(LenCap)) ?
                                        LenW'(LenCap) : arg_len_d[2]);
          out_rsp_d.fourth_length  = 4'((arg_len_d[3] > LenW'(LenCap)) ?
                                        LenW'(LenCap) : arg_len_d[3]);
        end

        // back to a clean line start
        at_start_d  = 1'b1;
        comment_d   = 1'b0;
        err_d       = 1'b0;
        tok_idx_d   = '0;
        in_tok_d    = 1'b0;
        lead_zero_d = 1'b0;
        cmd_byte_d  = '0;
        cmd_len_d   = '0;
        for (int i = 0; i < NumArgs; i++) begin
          arg_val_d[i] = '0;
          arg_len_d[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q  <= 1'b1;
      comment_q   <= 1'b0;
      err_q       <= 1'b0;
      tok_idx_q   <= '0;
      in_tok_q    <= 1'b0;
      lead_zero_q <= 1'b0;
      cmd_byte_q  <= '0;
      cmd_len_q   <= '0;
      for (int i = 0; i < NumArgs; i++) begin
        arg_val_q[i] <= '0;
        arg_len_q[i] <= '0;
      end
      out_vld_q   <= 1'b0;
    end else begin
      at_start_q  <= at_start_d;
      comment_q   <= comment_d;
      err_q       <= err_d;
      tok_idx_q   <= tok_idx_d;
      in_tok_q    <= in_tok_d;
      lead_zero_q <= lead_zero_d;
      cmd_byte_q  <= cmd_byte_d;
      cmd_len_q   <= cmd_len_d;
      for (int i = 0; i < NumArgs; i++) begin
        arg_val_q[i] <= arg_val_d[i];
        arg_len_q[i] <= arg_len_d[i];
      end
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
